FILE: hw/rtl/vdc_pkg.sv
package vdc_pkg;

  // Width of the reported slot number.
  localparam int unsigned SlotOutBits = 8;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_OUT
  } vdc_state_t;

endpackage

FILE: hw/rtl/vdc_pos_if.sv
interface vdc_pos_if #(
  parameter int unsigned COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: hw/rtl/vdc_res_if.sv
interface vdc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot_index;
  logic       is_new;

  modport source (output valid, slot_index, is_new, input ready);
  modport sink   (input valid, slot_index, is_new, output ready);
endinterface

FILE: hw/rtl/vertex_dedup_cache.sv
// Vertex position deduplication cache.
// The in_ channel carries one vertex position (x, y, z) per item. The out_
// channel returns one item per input: the table slot that holds the
// position and is_new, set when the position was just inserted.
// Positions live in one synchronous memory of ENTRIES words. Each item
// sweeps the table one slot per cycle: read one slot, compare in the next
// cycle, stopping at the first valid match or after the last slot. The
// sweep is serial, as the position memory has a single read port, and the
// registered result is valid in ST_OUT after the compare that hits or that
// checks the last slot. The next item can be taken in the cycle after the
// result leaves. On a miss the slot under the replacement pointer is written
// and the pointer moves on; slots fill from 0 upward, so replacement is
// first in, first out.
// Valid bits sit in flip-flops; reset clears them and the pointer at once,
// so no clearing pass is needed. The memory contents are left as they are.
// The result is held in an output register until the receiver takes it;
// a stalled receiver holds the block, and in_ready stays low meanwhile.
// Only one item is in work at a time.
module vertex_dedup_cache
  import vdc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  vdc_pos_if.sink                in_ch,
  vdc_res_if.source              out_ch
);

  localparam int unsigned IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WordBits = 3 * COORD_BITS;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [IdxBits-1:0]  idx_t;

  // Position memory, one word of x, y, z per slot.
  word_t mem [ENTRIES];
  word_t rd_data_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  idx_t       ptr_r, ptr_nxt;
  idx_t       scan_r, scan_nxt;
  idx_t       cmp_idx_r, cmp_idx_nxt;
  word_t      key_r, key_nxt;
  vdc_state_t state_r, state_nxt;
  logic [SlotOutBits-1:0] res_slot_r, res_slot_nxt;
  logic       res_new_r, res_new_nxt;
  logic       mem_we;
  idx_t       rd_addr;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Convert a slot number to the reported width.
  function automatic logic [SlotOutBits-1:0] to_out(input idx_t i);
    logic [SlotOutBits+IdxBits-1:0] w;
    w = {{SlotOutBits{1'b0}}, i};
    return w[SlotOutBits-1:0];
  endfunction

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    ptr_nxt      = ptr_r;
    scan_nxt     = scan_r;
    cmp_idx_nxt  = cmp_idx_r;
    key_nxt      = key_r;
    res_slot_nxt = res_slot_r;
    res_new_nxt  = res_new_r;
    mem_we       = 1'b0;
    rd_addr      = scan_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          key_nxt   = {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
          scan_nxt  = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // Read address is scan_r this cycle; compare it next.
        cmp_idx_nxt = scan_r;
        scan_nxt    = scan_r + idx_t'(1);
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        // Keep the read pipeline going at one slot per cycle.
        cmp_idx_nxt = scan_r;
        scan_nxt    = scan_r + idx_t'(1);
        if (valid_r[cmp_idx_r] && rd_data_r == key_r) begin
          res_slot_nxt = to_out(cmp_idx_r);
          res_new_nxt  = 1'b0;
          state_nxt    = ST_OUT;
        end else if (cmp_idx_r == idx_t'(ENTRIES - 1)) begin
          mem_we           = 1'b1;
          valid_nxt[ptr_r] = 1'b1;
          res_slot_nxt     = to_out(ptr_r);
          res_new_nxt      = 1'b1;
          ptr_nxt = (ptr_r == idx_t'(ENTRIES - 1)) ? '0 : ptr_r + idx_t'(1);
          state_nxt        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    key_r      <= key_nxt;
    res_slot_r <= res_slot_nxt;
    res_new_r  <= res_new_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = (state_r == ST_OUT);
  assign out_ch.slot_index = res_slot_r;
  assign out_ch.is_new     = res_new_r;

endmodule

FILE: test/tb_vdc_scoreboard.sv
`timescale 1ns / 100ps

// Scoreboard for the vertex deduplication cache. It keeps its own copy of
// the position table and predicts the slot and new-vertex flag per item.
class vdc_dedup_board;
  logic [31:0] tab_x [256];
  logic [31:0] tab_y [256];
  logic [31:0] tab_z [256];
  bit          tab_used [256];
  logic [7:0]  fill_ptr;
  logic [8:0]  pending_slots [$];
  int          mismatch_count;

  function void clear();
    foreach (tab_used[i]) tab_used[i] = 1'b0;
    fill_ptr = '0;
    pending_slots.delete();
    mismatch_count = 0;
  endfunction

  // Look the position up; on a miss it takes the slot under the pointer.
  function void note_position(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int   found;
    logic [7:0] slot;
    found = -1;
    for (int i = 0; i < 256; i++) begin
      if (found < 0 && tab_used[i] && tab_x[i] == x && tab_y[i] == y && tab_z[i] == z) begin
        found = i;
      end
    end
    if (found >= 0) begin
      pending_slots.push_back({1'b0, 8'(found)});
    end else begin
      slot = fill_ptr;
      tab_x[slot] = x;
      tab_y[slot] = y;
      tab_z[slot] = z;
      tab_used[slot] = 1'b1;
      fill_ptr = fill_ptr + 8'd1;
      pending_slots.push_back({1'b1, slot});
    end
  endfunction

  function void check_slot(logic [7:0] slot, logic is_new);
    logic [8:0] want;
    if (pending_slots.size() == 0) begin
      $display("%0t: unexpected result slot=%0d is_new=%0b", $time, slot, is_new);
      mismatch_count++;
      return;
    end
    want = pending_slots.pop_front();
    if (want[7:0] !== slot) begin
      $display("%0t: slot_index expected %0d actual %0d", $time, want[7:0], slot);
      mismatch_count++;
    end
    if (want[8] !== is_new) begin
      $display("%0t: is_new expected %0b actual %0b", $time, want[8], is_new);
      mismatch_count++;
    end
  endfunction
endclass

FILE: test/tb_vertex_dedup_cache.sv
`timescale 1ns / 100ps

module tb_vertex_dedup_cache;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   stimulus_done = 1'b0;
  logic [31:0] recent_x [$];
  logic [31:0] recent_y [$];
  logic [31:0] recent_z [$];
  vdc_dedup_board board = new();

  vdc_pos_if #(.COORD_BITS(32)) in_ch ();
  vdc_res_if out_ch ();

  vertex_dedup_cache dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stalls, set up at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted result is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_slot(out_ch.slot_index, out_ch.is_new);
    end
  end

  // Sends one position and waits until the block takes it. The item stays
  // driven until the next falling edge, where the next call or
  // wait_drained sets the valid line.
  task automatic send_position(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.pos_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    board.note_position(x, y, z);
    recent_x.push_back(x);
    recent_y.push_back(y);
    recent_z.push_back(z);
    if (recent_x.size() > 300) begin
      void'(recent_x.pop_front());
      void'(recent_y.pop_front());
      void'(recent_z.pop_front());
    end
  endtask

  // Random item: often a repeat of a recent position, some near misses, else small or fully random coordinates.
  task automatic send_random();
    logic [31:0] x, y, z;
    int pick;
    pick = $urandom_range(99);
    if (recent_x.size() > 0 && pick < 55) begin
      int k;
      k = $urandom_range(recent_x.size() - 1);
      x = recent_x[k];
      y = recent_y[k];
      z = recent_z[k];
      // Flip one bit of one coordinate now and then.
      if (pick < 10) begin
        case ($urandom_range(2))
          0: x[$urandom_range(31)] ^= 1'b1;
          1: y[$urandom_range(31)] ^= 1'b1;
          default: z[$urandom_range(31)] ^= 1'b1;
        endcase
      end
    end else if (pick < 75) begin
      x = $urandom_range(7);
      y = $urandom_range(7);
      z = $urandom_range(3);
    end else begin
      x = $urandom();
      y = $urandom();
      z = $urandom();
    end
    send_position(x, y, z);
  endtask

  // Drops the valid line and waits until every expected result has come.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending_slots.size() != 0) @(negedge clk);
  endtask

  initial begin
    board.clear();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme values, hits, single-field differences.
    send_position(32'h0, 32'h0, 32'h0);
    send_position(32'h0, 32'h0, 32'h0);
    send_position(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_position(32'h80000000, 32'h7fffffff, 32'h00000001);
    send_position(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_position(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_position(32'h1, 32'h0, 32'h0);
    send_position(32'h0, 32'h1, 32'h0);
    send_position(32'h0, 32'h0, 32'h1);
    send_position(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    send_position(32'h55555555, 32'haaaaaaaa, 32'h55555555);
    send_position(32'h0, 32'h0, 32'h0);
    send_position(32'hffffffff, 32'hffffffff, 32'hffffffff);
    wait_drained();

    // Random phases with sender idle and receiver stall patterns; the first and last have none.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 310; n++) begin
        send_random();
      end
      wait_drained();
    end
    stimulus_done = 1'b1;
  end

  // Finish once everything has drained, plus a short settle time.
  initial begin
    wait (stimulus_done);
    repeat (600) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending_slots.size() == 0) begin
      $display("vertex_dedup_cache test passed");
    end else begin
      $display("vertex_dedup_cache test failed");
    end
    $finish;
  end

  // Watchdog: worst case is about 1600 misses, each sweeping the whole table, under stalls.
  initial begin
    #80ms;
    $display("vertex_dedup_cache test failed");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/vdc_pkg.sv
hw/rtl/vdc_pos_if.sv
hw/rtl/vdc_res_if.sv
hw/rtl/vertex_dedup_cache.sv
test/tb_vdc_scoreboard.sv
test/tb_vertex_dedup_cache.sv
